FILE: rtl/bhq_pkg.sv
// shared types and constants for the binary max-heap priority queue
`timescale 1ns / 1ps
`default_nettype none

package bhq_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned COUNT_OUT_W = 8;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } bhq_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_CMP,
    ST_WRITE_KEY,
    ST_DONE
  } bhq_state_e;

  typedef logic signed [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

FILE: rtl/bhq_mem.sv
// heap key storage: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module bhq_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire  [AW-1:0]       waddr_i,
  input  bhq_pkg::key_t       wdata_i,
  input  wire  [AW-1:0]       raddr_a_i,
  input  wire  [AW-1:0]       raddr_b_i,
  output bhq_pkg::key_t       rdata_a_o,
  output bhq_pkg::key_t       rdata_b_o
);
  import bhq_pkg::*;

  key_t mem_q [DEPTH];
  key_t rdata_a_q;
  key_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

FILE: rtl/binary_max_heap_queue.sv
// top level: max-heap priority queue controller around the key memory
//
// Input channel: in_valid_i / in_stall_o carry one item, mode_i selects insert
// (MODE_INSERT) or extract-max (MODE_EXTRACT), item_value_i is the key to insert.
// Output channel: out_valid_o / out_stall_i carry one result per item:
// result_value_o (extracted key, zero otherwise), status_o (ok, full, empty)
// and count_after_o (keys held after the item, low 8 bits).
// Items are handled one at a time. The keys live in a memory with one write
// port and two registered read ports; the moving key is held in a register and
// each heap level is one step (read issued, then compare, write back and next
// read in the following cycle).
// Per item, at most ceil(log2(CAPACITY)) heap levels are compared; when the key
// lands at the root or at a leaf after a swap, it is written in a separate
// write-key step.
// The next item is taken as soon as the previous result is in the output
// register, even while that result is still stalled; a stalled result holds.
// Reset empties the queue at once (count to zero); no memory sweep is needed,
// since only entries below the count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 mode_i,
  input  bhq_pkg::key_t       item_value_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output bhq_pkg::key_t       result_value_o,
  output logic [1:0]          status_o,
  output logic [bhq_pkg::COUNT_OUT_W-1:0] count_after_o
);
  import bhq_pkg::*;

  localparam int unsigned AW  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CIW = AW + 2;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  bhq_state_e       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    pos_q, pos_d;
  key_t             key_q, key_d;
  key_t             res_q, res_d;
  bhq_status_e      stat_q, stat_d;

  logic             out_valid_q, out_valid_d;
  key_t             out_value_q, out_value_d;
  bhq_status_e      out_stat_q, out_stat_d;
  logic [CW-1:0]    out_count_q, out_count_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  key_t             mem_wdata;
  logic [AW-1:0]    mem_raddr_a;
  logic [AW-1:0]    mem_raddr_b;
  key_t             mem_rdata_a;
  key_t             mem_rdata_b;

  // child indexes carry two extra bits so they never wrap
  logic [CIW-1:0]   size_x;
  logic [CIW-1:0]   left_c;
  logic [CIW-1:0]   right_c;
  logic             right_ok;
  logic             pick_right;
  logic [AW-1:0]    pick_idx;
  key_t             pick_val;
  logic [CIW-1:0]   next_left;
  logic [CIW-1:0]   next_right;
  logic [AW-1:0]    parent_idx;
  logic [AW-1:0]    grand_idx;
  logic [AW-1:0]    ins_pos;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  bhq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign size_x     = CIW'(count_q);
  assign left_c     = {1'b0, pos_q, 1'b1};
  assign right_c    = left_c + CIW'(1);
  assign right_ok   = right_c < size_x;
  // equal children pick the right one
  assign pick_right = right_ok && !(mem_rdata_a > mem_rdata_b);
  assign pick_idx   = pick_right ? right_c[AW-1:0] : left_c[AW-1:0];
  assign pick_val   = pick_right ? mem_rdata_b : mem_rdata_a;
  assign next_left  = {1'b0, pick_idx, 1'b1};
  assign next_right = next_left + CIW'(1);
  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign grand_idx  = (parent_idx - AW'(1)) >> 1;
  assign ins_pos    = count_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    key_d       = key_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_stat_d  = out_stat_q;
    out_count_d = out_count_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = key_q;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    in_stall_o  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          res_d  = '0;
          stat_d = STATUS_OK;
          if (mode_i == MODE_INSERT) begin
            if (count_q == CAP_COUNT) begin
              stat_d  = STATUS_FULL;
              state_d = ST_DONE;
            end else begin
              key_d   = item_value_i;
              pos_d   = ins_pos;
              count_d = count_q + CW'(1);
              if (count_q == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = item_value_i;
                state_d   = ST_DONE;
              end else begin
                mem_raddr_a = (ins_pos - AW'(1)) >> 1;
                state_d     = ST_UP_CMP;
              end
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = STATUS_EMPTY;
              state_d = ST_DONE;
            end else begin
              mem_raddr_a = '0;
              mem_raddr_b = ins_pos - AW'(1);
              count_d     = count_q - CW'(1);
              state_d     = ST_DN_LOAD;
            end
          end
        end
      end

      ST_UP_CMP: begin
        if (key_q > mem_rdata_a) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = mem_rdata_a;
          pos_d     = parent_idx;
          if (parent_idx == '0) begin
            state_d = ST_WRITE_KEY;
          end else begin
            mem_raddr_a = grand_idx;
          end
        end else begin
          mem_we  = 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_DN_LOAD: begin
        // root is the result, last entry becomes the moving key
        res_d = mem_rdata_a;
        key_d = mem_rdata_b;
        pos_d = '0;
        if (count_q == '0) begin
          state_d = ST_DONE;
        end else if (count_q == CW'(1)) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = mem_rdata_b;
          state_d   = ST_DONE;
        end else begin
          mem_raddr_a = AW'(1);
          mem_raddr_b = (count_q > CW'(2)) ? AW'(2) : AW'(1);
          state_d     = ST_DN_CMP;
        end
      end

      ST_DN_CMP: begin
        if (key_q < pick_val) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = pick_val;
          pos_d     = pick_idx;
          if (next_left < size_x) begin
            mem_raddr_a = next_left[AW-1:0];
            mem_raddr_b = (next_right < size_x) ? next_right[AW-1:0] : next_left[AW-1:0];
          end else begin
            state_d = ST_WRITE_KEY;
          end
        end else begin
          mem_we  = 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_WRITE_KEY: begin
        mem_we  = 1'b1;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          out_stat_d  = stat_q;
          out_count_d = count_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    key_q       <= key_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    out_value_q <= out_value_d;
    out_stat_q  <= out_stat_d;
    out_count_q <= out_count_d;
  end

  assign count_ext      = {{COUNT_OUT_W{1'b0}}, out_count_q};
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_stat_q;
  assign count_after_o  = count_ext[COUNT_OUT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/bhq_checker.sv
// port-level checks for the heap queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bhq_checker #(
  parameter int unsigned CAPACITY = 128
) (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input bhq_pkg::key_t       result_value_o,
  input wire [1:0]           status_o,
  input wire [bhq_pkg::COUNT_OUT_W-1:0] count_after_o
);
  import bhq_pkg::*;

  localparam logic [COUNT_OUT_W-1:0] CAP_MOD = COUNT_OUT_W'(CAPACITY % 256);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o)
      && $stable(status_o) && $stable(count_after_o))
    else $error("stalled result changed");

  // refused items report a zero key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL || status_o == STATUS_EMPTY)
      |-> result_value_o == '0)
    else $error("refused item carries a key");

  // full refusal only at capacity, empty refusal only at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> count_after_o == CAP_MOD)
    else $error("full reported below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |-> count_after_o == '0)
    else $error("empty reported with keys held");

  // a result never appears unless an item was taken before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a pending item");

endmodule

bind binary_max_heap_queue bhq_checker #(
  .CAPACITY (CAPACITY)
) u_bhq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .status_o       (status_o),
  .count_after_o  (count_after_o)
);

`default_nettype wire

FILE: tb/tb_binary_max_heap_queue.sv
// self-checking testbench for the binary max-heap priority queue
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;
  import bhq_pkg::*;

  localparam int unsigned HEAP_DEPTH  = 128;
  localparam int unsigned RANDOM_OPS  = 870;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYC  = 30;

  typedef struct packed {
    key_t                   value;
    bhq_status_e            status;
    logic [COUNT_OUT_W-1:0] count;
  } heap_reply_t;

  typedef struct packed {
    logic        op;
    logic        rand_key;
    key_t        key_val;
    logic [15:0] reps;
    logic        typed;
    heap_reply_t want;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_style_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   mode = MODE_INSERT;
  key_t                   item_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  key_t                   result_value;
  logic [1:0]             status;
  logic [COUNT_OUT_W-1:0] count_after;

  // predictor state
  key_t        heap_keys [HEAP_DEPTH];
  int unsigned heap_size = 0;
  heap_reply_t pending_replies [$];
  stim_row_t   stim_rows [$];

  int unsigned items_sent = 0;
  int unsigned replies_checked = 0;
  int unsigned mismatches = 0;
  int unsigned refused_full = 0;
  int unsigned refused_empty = 0;
  int unsigned peak_fill = 0;
  int unsigned burst_left = 0;

  stall_style_e stall_style = STALL_NONE;
  int unsigned  stall_left = 0;
  logic [7:0]   stall_pat = 8'hA5;

  binary_max_heap_queue #(
    .CAPACITY(HEAP_DEPTH)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .item_value_i   (item_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value),
    .status_o       (status),
    .count_after_o  (count_after)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // applies one item to the software heap and returns what the block should answer
  task automatic heap_apply(input logic op, input key_t key_in, output heap_reply_t reply);
    int unsigned pos;
    int unsigned up;
    int unsigned lt;
    int unsigned rt;
    int unsigned pick;
    logic        done;
    key_t        tmp;
    reply.value  = '0;
    reply.status = STATUS_OK;
    done = 1'b0;
    if (op == MODE_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        reply.status = STATUS_FULL;
        refused_full++;
      end else begin
        pos = heap_size;
        heap_keys[pos] = key_in;
        heap_size++;
        while (!done && pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[pos] > heap_keys[up]) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[up];
            heap_keys[up] = tmp;
            pos = up;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (heap_size == 0) begin
        reply.status = STATUS_EMPTY;
        refused_empty++;
      end else begin
        reply.value = heap_keys[0];
        heap_size--;
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        while (!done) begin
          lt = 2 * pos + 1;
          rt = lt + 1;
          if (lt >= heap_size) begin
            done = 1'b1;
          end else begin
            // ties go to the right child
            pick = (rt >= heap_size || heap_keys[lt] > heap_keys[rt]) ? lt : rt;
            if (heap_keys[pos] < heap_keys[pick]) begin
              tmp = heap_keys[pos];
              heap_keys[pos] = heap_keys[pick];
              heap_keys[pick] = tmp;
              pos = pick;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
    end
    if (heap_size > peak_fill) peak_fill = heap_size;
    reply.count = COUNT_OUT_W'(heap_size);
  endtask

  // presents one item, holds it until taken, then records its expected reply
  task automatic send_item(input logic op, input key_t key_in, input logic typed,
                           input heap_reply_t want);
    heap_reply_t got;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    item_value <= key_in;
    do @(posedge clk); while (in_stall);
    heap_apply(op, key_in, got);
    pending_replies = {pending_replies, (typed ? want : got)};
    items_sent++;
    burst_left--;
  endtask

  task automatic add_row(input logic op, input logic rand_key, input key_t key_val,
                         input int unsigned reps, input logic typed, input key_t w_value,
                         input bhq_status_e w_status, input int unsigned w_count);
    stim_row_t row;
    row.op          = op;
    row.rand_key    = rand_key;
    row.key_val     = key_val;
    row.reps        = 16'(reps);
    row.typed       = typed;
    row.want.value  = w_value;
    row.want.status = w_status;
    row.want.count  = COUNT_OUT_W'(w_count);
    stim_rows = {stim_rows, row};
  endtask

  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 5))
      0, 1: k = key_t'($urandom);
      2:    k = key_t'($urandom_range(0, 8)) - key_t'(4);  // dense, many ties
      3:    k = key_t'($urandom_range(0, 255));
      4:    k = -key_t'($urandom_range(1, 65536));
      default: begin
        case ($urandom_range(0, 3))
          0:       k = 32'sh7FFFFFFF;
          1:       k = 32'sh80000000;
          2:       k = '0;
          default: k = -32'sd1;
        endcase
      end
    endcase
    return k;
  endfunction

  // receiver back-pressure, its own segments of styles
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = $urandom_range(20, 300);
      stall_pat   = 8'($urandom);
    end
    stall_left--;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        out_stall <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    endcase
  end

  always @(posedge clk) begin : check_replies
    heap_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with no item pending (value %0d status %0d)",
                                  result_value, status));
      end else begin
        want = pending_replies.pop_front();
        if (result_value !== want.value)
          report_mismatch($sformatf("result %0d: value got %0d want %0d",
                                    replies_checked, result_value, want.value));
        if (status !== want.status)
          report_mismatch($sformatf("result %0d: status got %0d want %0d",
                                    replies_checked, status, want.status));
        if (count_after !== want.count)
          report_mismatch($sformatf("result %0d: count got %0d want %0d",
                                    replies_checked, count_after, want.count));
        replies_checked++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_replies.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    heap_reply_t no_reply;
    key_t        k;
    int unsigned ins_pct;
    int unsigned seg_left;
    int unsigned n;
    no_reply = '0;
    ins_pct  = 50;
    seg_left = 0;

    // empty, extremes, ties, then full and drained
    add_row(MODE_EXTRACT, 0, '0, 1, 1, '0, STATUS_EMPTY, 0);
    add_row(MODE_INSERT, 0, 32'sh7FFFFFFF, 1, 1, '0, STATUS_OK, 1);
    add_row(MODE_INSERT, 0, 32'sh80000000, 1, 1, '0, STATUS_OK, 2);
    add_row(MODE_INSERT, 0, '0, 1, 1, '0, STATUS_OK, 3);
    add_row(MODE_INSERT, 0, -32'sd1, 1, 1, '0, STATUS_OK, 4);
    add_row(MODE_EXTRACT, 0, 32'sh5A5A5A5A, 1, 1, 32'sh7FFFFFFF, STATUS_OK, 3);
    add_row(MODE_EXTRACT, 0, '0, 1, 1, '0, STATUS_OK, 2);
    add_row(MODE_EXTRACT, 0, '0, 1, 1, -32'sd1, STATUS_OK, 1);
    add_row(MODE_EXTRACT, 0, '0, 1, 1, 32'sh80000000, STATUS_OK, 0);
    add_row(MODE_EXTRACT, 0, '0, 1, 1, '0, STATUS_EMPTY, 0);
    // equal children below the root, then a key equal to its parent
    add_row(MODE_INSERT, 0, 32'sd10, 1, 0, '0, STATUS_OK, 0);
    add_row(MODE_INSERT, 0, 32'sd7, 1, 0, '0, STATUS_OK, 0);
    add_row(MODE_INSERT, 0, 32'sd7, 1, 0, '0, STATUS_OK, 0);
    add_row(MODE_INSERT, 0, 32'sd1, 1, 0, '0, STATUS_OK, 0);
    add_row(MODE_EXTRACT, 0, '0, 1, 0, '0, STATUS_OK, 0);
    add_row(MODE_INSERT, 0, 32'sd7, 1, 0, '0, STATUS_OK, 0);
    add_row(MODE_EXTRACT, 0, '0, 4, 0, '0, STATUS_OK, 0);
    add_row(MODE_INSERT, 1, '0, HEAP_DEPTH, 0, '0, STATUS_OK, 0);
    add_row(MODE_INSERT, 0, '0, 1, 1, '0, STATUS_FULL, HEAP_DEPTH);
    add_row(MODE_INSERT, 0, 32'sh7FFFFFFF, 1, 1, '0, STATUS_FULL, HEAP_DEPTH);
    add_row(MODE_EXTRACT, 0, '0, HEAP_DEPTH, 0, '0, STATUS_OK, 0);
    add_row(MODE_EXTRACT, 0, '0, 1, 1, '0, STATUS_EMPTY, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[r]) begin
      for (n = 0; n < stim_rows[r].reps; n++) begin
        k = stim_rows[r].rand_key ? pick_key() : stim_rows[r].key_val;
        send_item(stim_rows[r].op, k, stim_rows[r].typed, stim_rows[r].want);
      end
    end

    // random phases that lean toward filling, mixing or draining
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 85;
          1:       ins_pct = 50;
          default: ins_pct = 15;
        endcase
        seg_left = $urandom_range(30, 200);
      end
      seg_left--;
      send_item(($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_EXTRACT,
                pick_key(), 1'b0, no_reply);
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("ran %0d items, checked %0d results, peak fill %0d of %0d",
             items_sent, replies_checked, peak_fill, HEAP_DEPTH);
    $display("refused inserts on full: %0d, refused extracts on empty: %0d, mismatches: %0d",
             refused_full, refused_empty, mismatches);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bhq_pkg.sv
rtl/bhq_mem.sv
rtl/binary_max_heap_queue.sv
rtl/bhq_checker.sv
tb/tb_binary_max_heap_queue.sv
